/* sv/framed_stack_macros.svh */
// Assertion macros for the framed stack RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef FRAMED_STACK_MACROS_SVH
`define FRAMED_STACK_MACROS_SVH
`ifndef SYNTHESIS
// Plain property, checked on every rising clock edge outside reset.
`define FS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication: when ante holds, cons must hold in the same cycle.
`define FS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Implication: when ante holds, cons must hold in the next cycle.
`define FS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FS_ASSERT(lbl, prop, msg)
`define FS_ASSERT_IMP(lbl, ante, cons, msg)
`define FS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/fs_pkg.sv */
// Package for the framed stack: opcodes, status codes, beat structs, FSM states.
// No dependencies.
package fs_pkg;

  localparam int StackDepthDef = 64;
  localparam int FrameDepthDef = 16;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_OPEN  = 2'd2,
    OP_CLOSE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_STACK_FULL  = 3'd1,
    ST_UNDERFLOW   = 3'd2,
    ST_FRAMES_FULL = 3'd3,
    ST_NO_FRAME    = 3'd4
  } status_e;

  typedef struct packed {
    op_e         opcode;
    logic [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic [31:0] pop_value;
    status_e     status;
  } out_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_e;

endpackage

/* sv/fs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/framed_stack.sv */
// Framed stack top level: control FSM, pointers and the two storage RAMs.
// Depends on fs_pkg, fs_ram and framed_stack_macros.svh.
//
// Usage
// - Input channel in_valid_i / in_stall_o carries one operation per beat
//   (push, pop, open frame, close frame) with the word to push.
// - Output channel out_valid_o / out_stall_i returns exactly one beat per
//   operation: the popped word (zero unless a pop) and a status code.
// - Each operation is accepted in S_IDLE: the accepting edge issues the read to
//   the word RAM or the frame RAM. In S_EXEC the update is applied and the
//   output register loaded. No new operation is accepted while one is in
//   S_EXEC, as the read data of those RAMs is registered. The result is valid
//   once the output register has been loaded at the end of S_EXEC.
// - The next beat is taken as soon as the update is done, even while the
//   output register is still full provided it drains on that same edge.
// - If the receiver stalls, the result holds in the output register and
//   in_stall_o stays high until it has been taken.
// - Reset empties the stack, closes all frames and clears the fill mark, so
//   that words never written read as zero. No clearing pass is needed; the
//   block is ready as soon as reset is released.
// - Saved frame pointers live in their own RAM and are read on every close;
//   the data is used only when a frame is open, after an open has written it.
`include "framed_stack_macros.svh"

module framed_stack
  import fs_pkg::*;
#(
  parameter int STACK_DEPTH = StackDepthDef,
  parameter int FRAME_DEPTH = FrameDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  // pointer width holds 0..STACK_DEPTH, address width indexes the word RAM
  localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVL_W  = $clog2(FRAME_DEPTH);
  localparam int FRM_W  = 2 * PTR_W;

  fsm_e state_q, state_d;

  op_e              op_q;
  logic [31:0]      word_q;
  logic [PTR_W-1:0] rd_idx_q;      // slot the pop reads
  logic [PTR_W-1:0] top_q, top_d;
  logic [PTR_W-1:0] bot_q, bot_d;
  logic [PTR_W-1:0] hwm_q, hwm_d;  // slots below this have been written
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             accept;
  logic [PTR_W-1:0] pop_idx;

  // word RAM ports
  logic              st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic [31:0]       st_rdata;
  logic              st_re;

  // frame RAM ports: {saved top, saved bottom}
  logic              fr_we;
  logic [LVL_W-1:0]  fr_raddr;
  logic [FRM_W-1:0]  fr_rdata;
  logic              fr_re;

  // ---------------------------------------------------------------------------
  // Input handshake and read issue
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // underflowing pop reads the top slot itself, a good pop reads the one below
  assign pop_idx  = (top_q <= bot_q) ? top_q : top_q - PTR_W'(1);
  assign st_re    = accept && (in_i.opcode == OP_POP);
  assign fr_re    = accept && (in_i.opcode == OP_CLOSE);
  assign fr_raddr = lvl_q - LVL_W'(1);

  fs_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_words (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (word_q),
    .re_i    (st_re),
    .raddr_i (pop_idx[ADDR_W-1:0]),
    .rdata_o (st_rdata)
  );

  fs_ram #(
    .WIDTH (FRM_W),
    .DEPTH (FRAME_DEPTH)
  ) u_frames (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (lvl_q),
    .wdata_i ({top_q, bot_q}),
    .re_i    (fr_re),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  // ---------------------------------------------------------------------------
  // FSM next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // FSM outputs: pointer update, RAM writes and result
  // ---------------------------------------------------------------------------
  always_comb begin
    top_d       = top_q;
    bot_d       = bot_q;
    hwm_d       = hwm_q;
    lvl_d       = lvl_q;
    st_we       = 1'b0;
    st_waddr    = top_q[ADDR_W-1:0];
    fr_we       = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
      end
      S_EXEC: begin
        out_valid_d     = 1'b1;
        out_d.pop_value = '0;
        out_d.status    = ST_OK;
        unique case (op_q)
          OP_PUSH: begin
            if (top_q == PTR_W'(STACK_DEPTH)) begin
              out_d.status = ST_STACK_FULL;
            end else begin
              st_we = 1'b1;
              top_d = top_q + PTR_W'(1);
              // top never exceeds the mark, so only equality raises it
              if (top_q == hwm_q) hwm_d = top_q + PTR_W'(1);
            end
          end
          OP_POP: begin
            if (top_q <= bot_q) begin
              out_d.status = ST_UNDERFLOW;
            end else begin
              top_d = top_q - PTR_W'(1);
            end
            // slots never written read as zero, as the word RAM itself is not reset
            out_d.pop_value = (rd_idx_q < hwm_q) ? st_rdata : '0;
          end
          OP_OPEN: begin
            if (lvl_q == LVL_W'(FRAME_DEPTH - 1)) begin
              out_d.status = ST_FRAMES_FULL;
            end else begin
              fr_we = 1'b1;
              lvl_d = lvl_q + LVL_W'(1);
              bot_d = top_q;
            end
          end
          OP_CLOSE: begin
            if (lvl_q == '0) begin
              out_d.status = ST_NO_FRAME;
            end else begin
              lvl_d = lvl_q - LVL_W'(1);
              top_d = fr_rdata[FRM_W-1:PTR_W];
              bot_d = fr_rdata[PTR_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      bot_q       <= '0;
      hwm_q       <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      bot_q       <= bot_d;
      hwm_q       <= hwm_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // beat payload, read index and result register, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_i.opcode;
      word_q   <= in_i.push_value;
      rd_idx_q <= pop_idx;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `FS_ASSERT(a_top_range, top_q <= PTR_W'(STACK_DEPTH), "top beyond stack depth")
  `FS_ASSERT(a_bot_le_top, bot_q <= top_q, "frame bottom above top")
  `FS_ASSERT(a_top_le_hwm, top_q <= hwm_q, "top above fill mark")
  `FS_ASSERT(a_lvl_range, lvl_q <= LVL_W'(FRAME_DEPTH - 1), "too many frames open")
  `FS_ASSERT_IMP(a_exec_out_free, state_q == S_EXEC, !out_valid_q, "result register busy")
  `FS_ASSERT_NXT(a_accept_exec, accept, state_q == S_EXEC, "accepted beat not executed")

endmodule
